FILE: hdl/mrrf_pkg.sv
// mrrf_pkg: constants, types and row helpers of the mesh relay route finder
// used by mrrf_row_mem, mesh_relay_route_finder, mrrf_route_checker and tb_top; depends on nothing
`timescale 1ns / 1ps

package mrrf_pkg;

  // node and level geometry
  localparam int MAX_NODES   = 16;
  localparam int NODE_W      = 4;
  localparam int LEVELS      = 4;
  localparam int LEVEL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ROW_W       = LEVELS * MAX_NODES;
  localparam int CNT_W       = 5;
  localparam int LOSS_W      = 8;
  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int HOPS_W      = 3;

  // loss thresholds, strictest level highest
  localparam int LOSS_TOP    = 120;
  localparam int LOSS_BOTTOM = 60;
  localparam int LOSS_STEP   = (LOSS_TOP - LOSS_BOTTOM) / LEVELS;
  localparam int TOP_PASS    = (LEVELS >= 2) ? LEVELS - 2 : 0;

  // hop counts reported in route_nodes
  localparam logic [HOPS_W-1:0] HOPS_NONE  = 3'd0;
  localparam logic [HOPS_W-1:0] HOPS_TWO   = 3'd2;
  localparam logic [HOPS_W-1:0] HOPS_THREE = 3'd3;
  localparam logic [HOPS_W-1:0] HOPS_FOUR  = 3'd4;

  localparam logic MODE_LINK  = 1'b0;
  localparam logic MODE_ROUTE = 1'b1;

  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [MAX_NODES-1:0] mask_t;
  typedef logic [NODE_W-1:0]    node_t;
  typedef logic [LEVEL_W-1:0]   level_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WA,
    S_WB,
    S_QAB,
    S_TWO,
    S_SCAN,
    S_KCHK,
    S_KCAP,
    S_DONE
  } state_t;

  // access request from the sequencer to the row store
  typedef struct packed {
    node_t rd0_addr;
    node_t rd1_addr;
    logic  we;
    node_t waddr;
    row_t  wdata;
  } mem_req_t;

  typedef struct packed {
    logic  hit;
    node_t relay;
  } match_t;

  // one level's neighbor row out of a node's word
  function automatic mask_t level_row(input row_t row, input int lev);
    level_row = row[lev*MAX_NODES +: MAX_NODES];
  endfunction

  // hide nodes outside the live count, whole row if the owner is outside
  function automatic row_t mask_row(input row_t row, input mask_t vmask, input logic keep);
    row_t res;
    res = '0;
    for (int l = 0; l < LEVELS; l++) begin
      res[l*MAX_NODES +: MAX_NODES] = keep ? (row[l*MAX_NODES +: MAX_NODES] & vmask) : '0;
    end
    mask_row = res;
  endfunction

  // set or clear one neighbor bit at every level by loss threshold
  function automatic row_t update_row(input row_t row, input node_t nb,
                                      input logic [LOSS_W-1:0] loss);
    row_t res;
    logic ok;
    res = row;
    for (int l = 0; l < LEVELS; l++) begin
      ok = (loss != '0) && (int'(loss) < (LOSS_TOP - l * LOSS_STEP));
      res[l*MAX_NODES + int'(nb)] = ok;
    end
    update_row = res;
  endfunction

  // strictest level at or above the pass with a shared neighbor, lowest relay
  function automatic match_t best_match(input row_t r1, input row_t r2, input level_t pass);
    match_t res;
    mask_t  c;
    logic   done;
    res  = '0;
    done = 1'b0;
    for (int l = LEVELS - 1; l >= 0; l--) begin
      c = level_row(r1, l) & level_row(r2, l);
      if (!done && (l >= int'(pass)) && (c != '0)) begin
        done    = 1'b1;
        res.hit = 1'b1;
        for (int b = MAX_NODES - 1; b >= 0; b--) begin
          if (c[b]) begin
            res.relay = NODE_W'(b);
          end
        end
      end
    end
    best_match = res;
  endfunction

  // neighbor test at a given pass level
  function automatic logic linked(input row_t row, input level_t pass, input node_t nb);
    mask_t m;
    m = row[int'(pass)*MAX_NODES +: MAX_NODES];
    linked = m[nb];
  endfunction

  function automatic logic [BYTE_W-1:0] node_byte(input node_t n);
    node_byte = {{(BYTE_W-NODE_W){1'b0}}, n};
  endfunction

endpackage

FILE: hdl/mrrf_row_mem.sv
// mrrf_row_mem: per-node neighbor rows, all levels in one word
// two registered read ports, one write port, row valid bits cleared by reset; uses mrrf_pkg
`timescale 1ns / 1ps

module mrrf_row_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  mrrf_pkg::mem_req_t req,
  output mrrf_pkg::row_t    rd0_data,
  output mrrf_pkg::row_t    rd1_data
);

  mrrf_pkg::row_t                 mem [mrrf_pkg::MAX_NODES];
  logic [mrrf_pkg::MAX_NODES-1:0] valid_r;
  mrrf_pkg::row_t                 rd0_q_r;
  mrrf_pkg::row_t                 rd1_q_r;
  logic                           rd0_vld_r;
  logic                           rd1_vld_r;

  // array write and registered reads
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd0_q_r <= mem[req.rd0_addr];
    rd1_q_r <= mem[req.rd1_addr];
  end

  // row valid bits, a never written row reads as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      rd0_vld_r <= 1'b0;
      rd1_vld_r <= 1'b0;
    end else begin
      if (req.we) begin
        valid_r[req.waddr] <= 1'b1;
      end
      rd0_vld_r <= valid_r[req.rd0_addr];
      rd1_vld_r <= valid_r[req.rd1_addr];
    end
  end

  assign rd0_data = rd0_vld_r ? rd0_q_r : '0;
  assign rd1_data = rd1_vld_r ? rd1_q_r : '0;

endmodule

FILE: hdl/mesh_relay_route_finder.sv
// mesh_relay_route_finder: link writes and route search over the neighbor row store
// depends on mrrf_pkg and mrrf_row_mem
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  in_mode, in_node_a, in_node_b, in_link_loss
//  out      output     out_valid/out_stall out_route_found, out_route_nodes, out_route_word
//  cfg      input      cfg_valid/cfg_ready cfg_node_count
//
// a link write reads both rows, writes one, then writes the other, and gives no result
// a route request captures both endpoint rows, then, for each of up to three passes,
//   runs the two-hop test and the three-hop scan, then fetches the row of each linked
//   far-end neighbor k and scans again; the single read port steps through candidate
//   relay rows, and a finished result waits in the done step while its output is stalled
// synchronous active-low reset empties all rows and sets node_count to 16
// the next request is taken while a result held in the output register waits on out_stall
`timescale 1ns / 1ps

module mesh_relay_route_finder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_mode,
  input  logic [mrrf_pkg::NODE_W-1:0]   in_node_a,
  input  logic [mrrf_pkg::NODE_W-1:0]   in_node_b,
  input  logic [mrrf_pkg::LOSS_W-1:0]   in_link_loss,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_route_found,
  output logic [mrrf_pkg::HOPS_W-1:0]   out_route_nodes,
  output logic [mrrf_pkg::WORD_W-1:0]   out_route_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrrf_pkg::CNT_W-1:0]    cfg_node_count
);

  localparam mrrf_pkg::node_t LAST_NODE = mrrf_pkg::NODE_W'(mrrf_pkg::MAX_NODES - 1);
  localparam mrrf_pkg::node_t FIRST_NODE = mrrf_pkg::NODE_W'(1);

  mrrf_pkg::state_t   state_r, state_nxt;
  mrrf_pkg::mem_req_t mem_req;
  mrrf_pkg::row_t     rd0_data, rd1_data;

  logic [mrrf_pkg::CNT_W-1:0] node_count_r;
  logic [mrrf_pkg::CNT_W-1:0] live;
  mrrf_pkg::mask_t            vmask;

  // request and search registers
  mrrf_pkg::node_t            a_r, a_nxt, b_r, b_nxt;
  logic [mrrf_pkg::LOSS_W-1:0] loss_r, loss_nxt;
  mrrf_pkg::row_t             ra_r, ra_nxt, rb_r, rb_nxt, rk_r, rk_nxt, wb_r, wb_nxt;
  mrrf_pkg::level_t           p_r, p_nxt;
  mrrf_pkg::node_t            sc_r, sc_nxt, ev_j_r, ev_j_nxt, k_r, k_nxt;
  logic                       ev_v_r, ev_v_nxt, iss_done_r, iss_done_nxt, four_r, four_nxt;

  // result staging and output register
  logic                        res_found_r, res_found_nxt;
  logic [mrrf_pkg::HOPS_W-1:0] res_nodes_r, res_nodes_nxt;
  logic [mrrf_pkg::WORD_W-1:0] res_word_r, res_word_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_found_r, out_found_nxt;
  logic [mrrf_pkg::HOPS_W-1:0] out_nodes_r, out_nodes_nxt;
  logic [mrrf_pkg::WORD_W-1:0] out_word_r, out_word_nxt;

  logic              in_acc;
  mrrf_pkg::match_t m_two, m_scan;
  mrrf_pkg::row_t    row_j, scan_target;
  logic              scan_hit;

  mrrf_row_mem u_row_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .rd0_data (rd0_data),
    .rd1_data (rd1_data)
  );

  // live node count and its neighbor mask
  always_comb begin
    live = (node_count_r > mrrf_pkg::CNT_W'(mrrf_pkg::MAX_NODES))
           ? mrrf_pkg::CNT_W'(mrrf_pkg::MAX_NODES) : node_count_r;
    for (int i = 0; i < mrrf_pkg::MAX_NODES; i++) begin
      vmask[i] = mrrf_pkg::CNT_W'(i) < live;
    end
  end

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= mrrf_pkg::CNT_W'(mrrf_pkg::MAX_NODES);
    end else if (cfg_valid && cfg_ready) begin
      node_count_r <= cfg_node_count;
    end
  end

  assign in_stall = (state_r != mrrf_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // match units for the two-hop test and the relay scan
  always_comb begin
    row_j       = mrrf_pkg::mask_row(rd0_data, vmask, {1'b0, ev_j_r} < live);
    scan_target = four_r ? rk_r : rb_r;
    m_two       = mrrf_pkg::best_match(ra_r, rb_r, p_r);
    m_scan      = mrrf_pkg::best_match(row_j, scan_target, p_r);
    scan_hit    = ev_v_r && mrrf_pkg::linked(ra_r, p_r, ev_j_r) && m_scan.hit;
  end

  // sequencer: next state, memory accesses and search bookkeeping
  always_comb begin
    state_nxt     = state_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    loss_nxt      = loss_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    rk_nxt        = rk_r;
    wb_nxt        = wb_r;
    p_nxt         = p_r;
    sc_nxt        = sc_r;
    ev_j_nxt      = ev_j_r;
    ev_v_nxt      = ev_v_r;
    iss_done_nxt  = iss_done_r;
    four_nxt      = four_r;
    k_nxt         = k_r;
    res_found_nxt = res_found_r;
    res_nodes_nxt = res_nodes_r;
    res_word_nxt  = res_word_r;
    mem_req       = '0;
    mem_req.rd0_addr = a_r;
    mem_req.rd1_addr = b_r;

    case (state_r)
      mrrf_pkg::S_IDLE: begin
        mem_req.rd0_addr = in_node_a;
        mem_req.rd1_addr = in_node_b;
        if (in_acc) begin
          a_nxt    = in_node_a;
          b_nxt    = in_node_b;
          loss_nxt = in_link_loss;
          if (in_mode == mrrf_pkg::MODE_ROUTE) begin
            state_nxt = mrrf_pkg::S_QAB;
          end else if (in_node_a != in_node_b) begin
            state_nxt = mrrf_pkg::S_WA;
          end
        end
      end

      // write the first node's row, hold the second
      mrrf_pkg::S_WA: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = a_r;
        mem_req.wdata = mrrf_pkg::update_row(rd0_data, b_r, loss_r);
        wb_nxt        = mrrf_pkg::update_row(rd1_data, a_r, loss_r);
        state_nxt     = mrrf_pkg::S_WB;
      end

      mrrf_pkg::S_WB: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = b_r;
        mem_req.wdata = wb_r;
        state_nxt     = mrrf_pkg::S_IDLE;
      end

      // capture endpoint rows
      mrrf_pkg::S_QAB: begin
        ra_nxt    = mrrf_pkg::mask_row(rd0_data, vmask, {1'b0, a_r} < live);
        rb_nxt    = mrrf_pkg::mask_row(rd1_data, vmask, {1'b0, b_r} < live);
        p_nxt     = mrrf_pkg::LEVEL_W'(mrrf_pkg::TOP_PASS);
        state_nxt = mrrf_pkg::S_TWO;
      end

      // two-hop test, else start the three-hop scan
      mrrf_pkg::S_TWO: begin
        if (m_two.hit) begin
          res_found_nxt = 1'b1;
          res_nodes_nxt = mrrf_pkg::HOPS_TWO;
          res_word_nxt  = {16'h0000, mrrf_pkg::node_byte(b_r),
                           mrrf_pkg::node_byte(m_two.relay)};
          state_nxt     = mrrf_pkg::S_DONE;
        end else begin
          sc_nxt       = FIRST_NODE;
          ev_v_nxt     = 1'b0;
          iss_done_nxt = 1'b0;
          four_nxt     = 1'b0;
          state_nxt    = mrrf_pkg::S_SCAN;
        end
      end

      // relay scan over first hops j, each row read issued the cycle before its test
      mrrf_pkg::S_SCAN: begin
        mem_req.rd0_addr = sc_r;
        if (!iss_done_r) begin
          ev_j_nxt = sc_r;
          ev_v_nxt = 1'b1;
          sc_nxt   = sc_r + 1'b1;
          if (sc_r == LAST_NODE) begin
            iss_done_nxt = 1'b1;
          end
        end else begin
          ev_v_nxt = 1'b0;
        end
        if (scan_hit) begin
          res_found_nxt = 1'b1;
          if (four_r) begin
            res_nodes_nxt = mrrf_pkg::HOPS_FOUR;
            res_word_nxt  = {mrrf_pkg::node_byte(b_r), mrrf_pkg::node_byte(k_r),
                             mrrf_pkg::node_byte(m_scan.relay), mrrf_pkg::node_byte(ev_j_r)};
          end else begin
            res_nodes_nxt = mrrf_pkg::HOPS_THREE;
            res_word_nxt  = {8'h00, mrrf_pkg::node_byte(b_r),
                             mrrf_pkg::node_byte(m_scan.relay), mrrf_pkg::node_byte(ev_j_r)};
          end
          state_nxt = mrrf_pkg::S_DONE;
        end else if (ev_v_r && (ev_j_r == LAST_NODE)) begin
          if (!four_r) begin
            four_nxt  = 1'b1;
            k_nxt     = FIRST_NODE;
            state_nxt = mrrf_pkg::S_KCHK;
          end else if (k_r != LAST_NODE) begin
            k_nxt     = k_r + 1'b1;
            state_nxt = mrrf_pkg::S_KCHK;
          end else if (p_r == '0) begin
            res_found_nxt = 1'b0;
            res_nodes_nxt = mrrf_pkg::HOPS_NONE;
            res_word_nxt  = '0;
            state_nxt     = mrrf_pkg::S_DONE;
          end else begin
            p_nxt     = p_r - 1'b1;
            state_nxt = mrrf_pkg::S_TWO;
          end
        end
      end

      // next far-end neighbor k, fetch its row if linked
      mrrf_pkg::S_KCHK: begin
        mem_req.rd0_addr = k_r;
        if (mrrf_pkg::linked(rb_r, p_r, k_r)) begin
          state_nxt = mrrf_pkg::S_KCAP;
        end else if (k_r != LAST_NODE) begin
          k_nxt = k_r + 1'b1;
        end else if (p_r == '0) begin
          res_found_nxt = 1'b0;
          res_nodes_nxt = mrrf_pkg::HOPS_NONE;
          res_word_nxt  = '0;
          state_nxt     = mrrf_pkg::S_DONE;
        end else begin
          p_nxt     = p_r - 1'b1;
          state_nxt = mrrf_pkg::S_TWO;
        end
      end

      mrrf_pkg::S_KCAP: begin
        rk_nxt       = mrrf_pkg::mask_row(rd0_data, vmask, {1'b0, k_r} < live);
        sc_nxt       = FIRST_NODE;
        ev_v_nxt     = 1'b0;
        iss_done_nxt = 1'b0;
        state_nxt    = mrrf_pkg::S_SCAN;
      end

      // hand the result to the output register once it is free
      mrrf_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = mrrf_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mrrf_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_nodes_nxt = out_nodes_r;
    out_word_nxt  = out_word_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == mrrf_pkg::S_DONE) && (!out_valid_r || !out_stall)) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = res_found_r;
      out_nodes_nxt = res_nodes_r;
      out_word_nxt  = res_word_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrrf_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      ev_v_r      <= 1'b0;
      iss_done_r  <= 1'b0;
      four_r      <= 1'b0;
      p_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ev_v_r      <= ev_v_nxt;
      iss_done_r  <= iss_done_nxt;
      four_r      <= four_nxt;
      p_r         <= p_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    loss_r      <= loss_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    rk_r        <= rk_nxt;
    wb_r        <= wb_nxt;
    sc_r        <= sc_nxt;
    ev_j_r      <= ev_j_nxt;
    k_r         <= k_nxt;
    res_found_r <= res_found_nxt;
    res_nodes_r <= res_nodes_nxt;
    res_word_r  <= res_word_nxt;
    out_found_r <= out_found_nxt;
    out_nodes_r <= out_nodes_nxt;
    out_word_r  <= out_word_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_route_found = out_found_r;
  assign out_route_nodes = out_nodes_r;
  assign out_route_word  = out_word_r;

  // row store is written only by the two link write steps
  a_we_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> (state_r == mrrf_pkg::S_WA || state_r == mrrf_pkg::S_WB))
    else $error("row write outside link write steps");

  // a new result appears only out of the done step
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == mrrf_pkg::S_DONE))
    else $error("result loaded without a finished search");

  // found flag agrees with the hop count
  a_found_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_found_r == (out_nodes_r != mrrf_pkg::HOPS_NONE)))
    else $error("route_found and route_nodes disagree");

  // pass level never above the first pass
  a_pass_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != mrrf_pkg::S_IDLE |-> p_r <= mrrf_pkg::LEVEL_W'(mrrf_pkg::TOP_PASS))
    else $error("pass level out of range");

  // scan never tests node zero as a first hop
  a_scan_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mrrf_pkg::S_SCAN && ev_v_r) |-> ev_j_r != '0)
    else $error("relay scan reached node zero");

endmodule

FILE: verif/mrrf_route_checker.sv
// mrrf_route_checker: watches the link, route and node_count channels of the route finder,
// keeps its own copy of the neighbor rows and checks every route result in order
// depends on mrrf_pkg for widths, node type and hop codes
`timescale 1ns / 1ps

module mrrf_route_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        in_mode,
  input  mrrf_pkg::node_t             in_node_a,
  input  mrrf_pkg::node_t             in_node_b,
  input  logic [mrrf_pkg::LOSS_W-1:0] in_link_loss,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_route_found,
  input  logic [mrrf_pkg::HOPS_W-1:0] out_route_nodes,
  input  logic [mrrf_pkg::WORD_W-1:0] out_route_word,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [mrrf_pkg::CNT_W-1:0]  cfg_node_count,
  output int                          route_errors,
  output int                          routes_pending
);

  typedef struct packed {
    logic                        found;
    logic [mrrf_pkg::HOPS_W-1:0] nodes;
    logic [mrrf_pkg::WORD_W-1:0] word;
    mrrf_pkg::node_t             src;
    mrrf_pkg::node_t             dst;
  } route_t;

  // neighbor rows per level, strictest level highest
  mrrf_pkg::mask_t            link_rows [mrrf_pkg::LEVELS][mrrf_pkg::MAX_NODES];
  logic [mrrf_pkg::CNT_W-1:0] live_nodes;
  route_t                     expected_routes [$];
  route_t                     want;

  initial begin
    route_errors   = 0;
    routes_pending = 0;
  end

  // row as a query sees it: empty for nodes outside the live count
  function automatic mrrf_pkg::mask_t row_at(input int lev, input int n);
    int              cnt;
    mrrf_pkg::mask_t vis;
    cnt = (int'(live_nodes) > mrrf_pkg::MAX_NODES) ? mrrf_pkg::MAX_NODES : int'(live_nodes);
    if (n >= cnt) return '0;
    vis = mrrf_pkg::mask_t'((32'd1 << cnt) - 32'd1);
    return link_rows[lev][n] & vis;
  endfunction

  function automatic logic has_link(input int lev, input int n, input int nb);
    mrrf_pkg::mask_t r;
    r = row_at(lev, n);
    return r[nb];
  endfunction

  // strictest level where both nodes share a neighbor, lowest such neighbor as relay
  function automatic int shared_relay(input int n1, input int n2, output int relay);
    mrrf_pkg::mask_t both;
    relay = 0;
    for (int l = mrrf_pkg::LEVELS - 1; l >= 0; l--) begin
      both = row_at(l, n1) & row_at(l, n2);
      if (both != '0) begin
        for (int b = mrrf_pkg::MAX_NODES - 1; b >= 0; b--) begin
          if (both[b]) relay = b;
        end
        return l;
      end
    end
    return -1;
  endfunction

  // set or clear the pair at each level by its loss threshold
  function automatic void apply_link(input mrrf_pkg::node_t a, input mrrf_pkg::node_t b,
                                     input logic [mrrf_pkg::LOSS_W-1:0] loss);
    logic ok;
    if (a == b) return;
    for (int l = 0; l < mrrf_pkg::LEVELS; l++) begin
      ok = (loss != '0) &&
           (int'(loss) < mrrf_pkg::LOSS_TOP - l * mrrf_pkg::LOSS_STEP);
      link_rows[l][a][b] = ok;
      link_rows[l][b][a] = ok;
    end
  endfunction

  // route search: two, three then four hops, pass by pass from strict to lax
  function automatic route_t find_route(input mrrf_pkg::node_t src,
                                        input mrrf_pkg::node_t dst);
    route_t res;
    int     relay;
    res     = '0;
    res.src = src;
    res.dst = dst;
    for (int p = mrrf_pkg::TOP_PASS; p >= 0; p--) begin
      if (shared_relay(src, dst, relay) >= p) begin
        res.found = 1'b1;
        res.nodes = mrrf_pkg::HOPS_TWO;
        res.word  = mrrf_pkg::WORD_W'(relay) | (mrrf_pkg::WORD_W'(dst) << 8);
        return res;
      end
      for (int j = 1; j < mrrf_pkg::MAX_NODES; j++) begin
        if (has_link(p, src, j) && shared_relay(j, dst, relay) >= p) begin
          res.found = 1'b1;
          res.nodes = mrrf_pkg::HOPS_THREE;
          res.word  = mrrf_pkg::WORD_W'(j) | (mrrf_pkg::WORD_W'(relay) << 8) |
                      (mrrf_pkg::WORD_W'(dst) << 16);
          return res;
        end
      end
      for (int k = 1; k < mrrf_pkg::MAX_NODES; k++) begin
        if (!has_link(p, dst, k)) continue;
        for (int j = 1; j < mrrf_pkg::MAX_NODES; j++) begin
          if (has_link(p, src, j) && shared_relay(j, k, relay) >= p) begin
            res.found = 1'b1;
            res.nodes = mrrf_pkg::HOPS_FOUR;
            res.word  = mrrf_pkg::WORD_W'(j) | (mrrf_pkg::WORD_W'(relay) << 8) |
                        (mrrf_pkg::WORD_W'(k) << 16) | (mrrf_pkg::WORD_W'(dst) << 24);
            return res;
          end
        end
      end
    end
    return res;
  endfunction

  task automatic report_field(input string name, input logic [mrrf_pkg::WORD_W-1:0] exp_val,
                              input logic [mrrf_pkg::WORD_W-1:0] got_val);
    if (route_errors < 40)
      $display("%0t: %s wrong for route %0d->%0d: expected %0h, actual %0h",
               $time, name, want.src, want.dst, exp_val, got_val);
    route_errors++;
  endtask

  // sample every channel at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int l = 0; l < mrrf_pkg::LEVELS; l++)
        for (int n = 0; n < mrrf_pkg::MAX_NODES; n++)
          link_rows[l][n] = '0;
      live_nodes = mrrf_pkg::CNT_W'(mrrf_pkg::MAX_NODES);
      expected_routes.delete();
    end else begin
      // accepted result against the oldest expected route
      if (out_valid && !out_stall) begin
        if (expected_routes.size() == 0) begin
          if (route_errors < 40)
            $display("%0t: result with no request waiting: found %0d nodes %0d word %0h",
                     $time, out_route_found, out_route_nodes, out_route_word);
          route_errors++;
        end else begin
          want = expected_routes.pop_front();
          if (out_route_found !== want.found)
            report_field("route_found", mrrf_pkg::WORD_W'(want.found),
                         mrrf_pkg::WORD_W'(out_route_found));
          if (out_route_nodes !== want.nodes)
            report_field("route_nodes", mrrf_pkg::WORD_W'(want.nodes),
                         mrrf_pkg::WORD_W'(out_route_nodes));
          if (out_route_word !== want.word)
            report_field("route_word", want.word, out_route_word);
        end
      end
      if (cfg_valid && cfg_ready) live_nodes = cfg_node_count;
      // accepted request: link write or route query
      if (in_valid && !in_stall) begin
        if (in_mode == mrrf_pkg::MODE_ROUTE)
          expected_routes.push_back(find_route(in_node_a, in_node_b));
        else apply_link(in_node_a, in_node_b, in_link_loss);
      end
    end
    routes_pending = expected_routes.size();
  end

endmodule

FILE: verif/tb_top.sv
// tb_top: drives link writes, route queries and node_count changes into the route finder
// with random gaps and stalls; depends on mrrf_pkg, mesh_relay_route_finder, mrrf_route_checker
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE      = 10;
  localparam int PHASE_ITEMS = 90;
  localparam int PHASES      = 8;

  logic                        clk            = 1'b0;
  logic                        rst_n          = 1'b0;
  logic                        in_valid       = 1'b0;
  logic                        in_stall;
  logic                        in_mode        = mrrf_pkg::MODE_LINK;
  mrrf_pkg::node_t             in_node_a      = '0;
  mrrf_pkg::node_t             in_node_b      = '0;
  logic [mrrf_pkg::LOSS_W-1:0] in_link_loss   = '0;
  logic                        out_valid;
  logic                        out_stall      = 1'b0;
  logic                        out_route_found;
  logic [mrrf_pkg::HOPS_W-1:0] out_route_nodes;
  logic [mrrf_pkg::WORD_W-1:0] out_route_word;
  logic                        cfg_valid      = 1'b0;
  logic                        cfg_ready;
  logic [mrrf_pkg::CNT_W-1:0]  cfg_node_count = mrrf_pkg::CNT_W'(mrrf_pkg::MAX_NODES);

  int   route_errors;
  int   routes_pending;
  int   cycle_count = 0;
  int   items_sent  = 0;
  logic quiet       = 1'b0;
  int   node_plan [PHASES] = '{16, 2, 5, 9, 16, 3, 12, 16};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mesh_relay_route_finder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_node_a      (in_node_a),
    .in_node_b      (in_node_b),
    .in_link_loss   (in_link_loss),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_route_found(out_route_found),
    .out_route_nodes(out_route_nodes),
    .out_route_word (out_route_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count)
  );

  mrrf_route_checker route_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_node_a      (in_node_a),
    .in_node_b      (in_node_b),
    .in_link_loss   (in_link_loss),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_route_found(out_route_found),
    .out_route_nodes(out_route_nodes),
    .out_route_word (out_route_word),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_node_count (cfg_node_count),
    .route_errors   (route_errors),
    .routes_pending (routes_pending)
  );

  // receiver stalls now and then, never in the quiet stretch
  always @(negedge clk) out_stall <= !quiet && ($urandom_range(99) < 8);

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // one request, held until accepted
  task automatic send_req(input logic mode, input mrrf_pkg::node_t a,
                          input mrrf_pkg::node_t b,
                          input logic [mrrf_pkg::LOSS_W-1:0] loss);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_node_a    <= a;
    in_node_b    <= b;
    in_link_loss <= loss;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // stop sending and wait for every route, then let a link write finish
  task automatic drain_routes();
    @(negedge clk);
    in_valid <= 1'b0;
    while (routes_pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_node_count(input int count);
    @(negedge clk);
    cfg_valid      <= 1'b1;
    cfg_node_count <= mrrf_pkg::CNT_W'(count);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly live nodes, sometimes any node
  function automatic mrrf_pkg::node_t pick_node(input int span);
    if ($urandom_range(7) == 0)
      return mrrf_pkg::node_t'($urandom_range(mrrf_pkg::MAX_NODES - 1));
    return mrrf_pkg::node_t'($urandom_range(span - 1));
  endfunction

  // loss spread over every level band, plus no-link values
  function automatic logic [mrrf_pkg::LOSS_W-1:0] pick_loss();
    case ($urandom_range(7))
      0:       return '0;
      1:       return mrrf_pkg::LOSS_W'($urandom_range(120, 255));
      2:       return mrrf_pkg::LOSS_W'($urandom_range(105, 119));
      3:       return mrrf_pkg::LOSS_W'($urandom_range(90, 104));
      4:       return mrrf_pkg::LOSS_W'($urandom_range(75, 89));
      default: return mrrf_pkg::LOSS_W'($urandom_range(1, 74));
    endcase
  endfunction

  // build a path of two to four hops and ask for it, sometimes with a link cut
  task automatic run_chain(input int span);
    mrrf_pkg::node_t                hop [5];
    int                             hops;
    int                             n;
    int                             pick;
    logic [mrrf_pkg::MAX_NODES-1:0] used;
    logic [mrrf_pkg::LOSS_W-1:0]    loss;
    hops = $urandom_range(2, 4);
    n    = (span < 5) ? 5 : span;
    used = '0;
    for (int i = 0; i <= hops; i++) begin
      do pick = $urandom_range(n - 1); while (used[pick]);
      used[pick] = 1'b1;
      hop[i]     = mrrf_pkg::node_t'(pick);
    end
    for (int i = 0; i < hops; i++) begin
      loss = ($urandom_range(9) == 0) ? pick_loss()
                                      : mrrf_pkg::LOSS_W'($urandom_range(1, 119));
      if ($urandom_range(1) == 0) send_req(mrrf_pkg::MODE_LINK, hop[i], hop[i+1], loss);
      else send_req(mrrf_pkg::MODE_LINK, hop[i+1], hop[i], loss);
    end
    if ($urandom_range(1) == 0)
      send_req(mrrf_pkg::MODE_ROUTE, hop[0], hop[hops],
               mrrf_pkg::LOSS_W'($urandom_range(255)));
    else
      send_req(mrrf_pkg::MODE_ROUTE, hop[hops], hop[0],
               mrrf_pkg::LOSS_W'($urandom_range(255)));
  endtask

  // drop the links of one node to every node below span so the mesh stays sparse
  task automatic clear_node(input int span);
    mrrf_pkg::node_t hub;
    hub = pick_node(span);
    for (int y = 0; y < span; y++)
      send_req(mrrf_pkg::MODE_LINK, hub, mrrf_pkg::node_t'(y),
               ($urandom_range(1) == 0) ? '0 : mrrf_pkg::LOSS_W'($urandom_range(120, 255)));
  endtask

  task automatic random_step(input int span);
    int r;
    r = $urandom_range(99);
    if (r < 55) run_chain(span);
    else if (r < 75)
      send_req(mrrf_pkg::MODE_LINK, pick_node(span), pick_node(span), pick_loss());
    else if (r < 92)
      send_req(mrrf_pkg::MODE_ROUTE, pick_node(span), pick_node(span),
               mrrf_pkg::LOSS_W'($urandom_range(255)));
    else clear_node(span);
  endtask

  initial begin
    int target;
    logic paused;
    paused = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: self link, field extremes, each level band, two/three/four hops, none
    send_req(mrrf_pkg::MODE_LINK,  4'd3,  4'd3,  8'd50);
    send_req(mrrf_pkg::MODE_LINK,  4'd0,  4'd15, 8'd255);
    send_req(mrrf_pkg::MODE_LINK,  4'd15, 4'd0,  8'd1);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd0,  4'd15, 8'd0);
    send_req(mrrf_pkg::MODE_LINK,  4'd1,  4'd2,  8'd74);
    send_req(mrrf_pkg::MODE_LINK,  4'd2,  4'd3,  8'd75);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd1,  4'd3,  8'd255);
    send_req(mrrf_pkg::MODE_LINK,  4'd3,  4'd4,  8'd89);
    send_req(mrrf_pkg::MODE_LINK,  4'd4,  4'd5,  8'd90);
    send_req(mrrf_pkg::MODE_LINK,  4'd5,  4'd6,  8'd104);
    send_req(mrrf_pkg::MODE_LINK,  4'd6,  4'd7,  8'd105);
    send_req(mrrf_pkg::MODE_LINK,  4'd7,  4'd8,  8'd119);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd1,  4'd4,  8'd0);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd1,  4'd5,  8'd0);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd4,  4'd8,  8'd0);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd1,  4'd8,  8'd0);
    send_req(mrrf_pkg::MODE_LINK,  4'd8,  4'd9,  8'd120);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd7,  4'd9,  8'd0);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd2,  4'd2,  8'd0);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd15, 4'd15, 8'd255);
    send_req(mrrf_pkg::MODE_LINK,  4'd2,  4'd3,  8'd0);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd1,  4'd4,  8'd0);
    send_req(mrrf_pkg::MODE_ROUTE, 4'd15, 4'd1,  8'd0);

    // random phases, each at its own node count
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_routes();
      write_node_count(node_plan[ph]);
      quiet  = (ph == 3);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if (ph == 5 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
          paused = 1'b1;
          drain_routes();
        end
        random_step(node_plan[ph]);
      end
    end
    quiet = 1'b0;
    drain_routes();

    if (route_errors == 0 && routes_pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
